>>> rtl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// shared types and sizes for the lru key-value cache
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

  // store geometry
  localparam int CAPACITY    = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;

  // field width of the words on the channels
  localparam int FIELD_W = 32;

  // slot index and recency rank share one width; the fill count can hold CAPACITY
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // operation codes
  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  typedef logic [KEY_WIDTH-1:0]   key_t;
  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  // request word
  typedef struct packed {
    logic               func;
    logic [FIELD_W-1:0] lookup_key;
    logic [FIELD_W-1:0] store_value;
  } req_t;

  // response word
  typedef struct packed {
    logic               hit;
    logic [FIELD_W-1:0] read_value;
    logic               evicted;
    logic [FIELD_W-1:0] evicted_key;
  } rsp_t;

endpackage

`default_nettype wire

>>> rtl/lkvc_store.sv
// ----------------------------------------------------------------------------
// lkvc_store
// entry storage, associative lookup and recency rank update
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_store (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire lkvc_pkg::req_t req,
  output lkvc_pkg::rsp_t     rsp
);

  lkvc_pkg::key_t   keys   [lkvc_pkg::CAPACITY];
  lkvc_pkg::value_t values [lkvc_pkg::CAPACITY];
  logic             valid  [lkvc_pkg::CAPACITY];
  lkvc_pkg::idx_t   rank   [lkvc_pkg::CAPACITY];
  lkvc_pkg::cnt_t   fill;

  lkvc_pkg::idx_t   rank_next [lkvc_pkg::CAPACITY];
  lkvc_pkg::key_t   key;
  lkvc_pkg::value_t val;
  logic             is_put;
  logic             hit;
  logic             full;
  logic             free_found;
  logic             victim_found;
  lkvc_pkg::idx_t   hit_slot;
  lkvc_pkg::idx_t   free_slot;
  lkvc_pkg::idx_t   victim_slot;
  lkvc_pkg::idx_t   slot;
  lkvc_pkg::cnt_t   old_rank;
  logic             do_touch;
  logic             do_write;
  logic             do_insert;
  logic             do_evict;

  assign key    = lkvc_pkg::KEY_WIDTH'(req.lookup_key);
  assign val    = lkvc_pkg::VALUE_WIDTH'(req.store_value);
  assign is_put = (req.func == lkvc_pkg::FUNC_PUT);
  assign full   = (fill == lkvc_pkg::cnt_t'(lkvc_pkg::CAPACITY));

  // priority searches, lowest slot wins
  always_comb begin
    hit          = 1'b0;
    hit_slot     = '0;
    free_found   = 1'b0;
    free_slot    = '0;
    victim_found = 1'b0;
    victim_slot  = '0;
    for (int i = 0; i < lkvc_pkg::CAPACITY; i++) begin
      if (!hit && valid[i] && keys[i] == key) begin
        hit      = 1'b1;
        hit_slot = lkvc_pkg::idx_t'(i);
      end
      if (!free_found && !valid[i]) begin
        free_found = 1'b1;
        free_slot  = lkvc_pkg::idx_t'(i);
      end
      if (!victim_found && valid[i] &&
          rank[i] == lkvc_pkg::idx_t'(lkvc_pkg::CAPACITY - 1)) begin
        victim_found = 1'b1;
        victim_slot  = lkvc_pkg::idx_t'(i);
      end
    end
  end

  // pick the slot to touch and the rank it leaves
  always_comb begin
    slot      = hit_slot;
    old_rank  = lkvc_pkg::cnt_t'(rank[hit_slot]);
    do_touch  = 1'b0;
    do_write  = 1'b0;
    do_insert = 1'b0;
    do_evict  = 1'b0;
    if (hit) begin
      do_touch = 1'b1;
      do_write = is_put;
    end else if (is_put && !full) begin
      // new key while room is left
      slot      = free_slot;
      old_rank  = lkvc_pkg::cnt_t'(lkvc_pkg::CAPACITY);
      do_touch  = free_found;
      do_write  = free_found;
      do_insert = free_found;
    end else if (is_put) begin
      // store full: replace the least recent entry
      slot     = victim_slot;
      old_rank = lkvc_pkg::cnt_t'(lkvc_pkg::CAPACITY - 1);
      do_touch = 1'b1;
      do_write = 1'b1;
      do_evict = 1'b1;
    end
  end

  // entries more recent than the touched one move down by one
  always_comb begin
    for (int j = 0; j < lkvc_pkg::CAPACITY; j++) begin
      rank_next[j] = rank[j];
      if (do_touch) begin
        if (lkvc_pkg::idx_t'(j) == slot) begin
          rank_next[j] = '0;
        end else if (valid[j] && lkvc_pkg::cnt_t'(rank[j]) < old_rank) begin
          rank_next[j] = rank[j] + lkvc_pkg::idx_t'(1);
        end
      end
    end
  end

  always_comb begin
    rsp.hit         = hit;
    rsp.read_value  = (hit && !is_put) ? lkvc_pkg::FIELD_W'(values[hit_slot]) : '0;
    rsp.evicted     = do_evict;
    rsp.evicted_key = do_evict ? lkvc_pkg::FIELD_W'(keys[victim_slot]) : '0;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      for (int i = 0; i < lkvc_pkg::CAPACITY; i++) begin
        valid[i] <= 1'b0;
        rank[i]  <= '0;
      end
    end else if (adv) begin
      for (int i = 0; i < lkvc_pkg::CAPACITY; i++) begin
        rank[i] <= rank_next[i];
      end
      if (do_write) begin
        valid[slot] <= 1'b1;
      end
      if (do_insert) begin
        fill <= fill + lkvc_pkg::cnt_t'(1);
      end
    end
  end

  // key and value payload
  always_ff @(posedge clk) begin
    if (adv && do_write) begin
      values[slot] <= val;
      if (!hit) begin
        keys[slot] <= key;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/lru_key_value_cache_top.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// fully associative key-value cache with least-recently-used replacement
// ----------------------------------------------------------------------------
// usage
//   req channel: one word per get or put (func, lookup_key, store_value),
//     taken at a clock edge with req_valid high and req_stall low
//   rsp channel: one word per request (hit, read_value, evicted, evicted_key),
//     taken at a clock edge with rsp_valid high and rsp_stall low
//   order: a request taken into the request register has its response
//     loaded into the response register when it moves on (adv high)
//   throughput: one request per cycle unless rsp_stall holds a response;
//     the lookup against all entries and the rank update are combinational
//     between the request and response registers, the store updates when
//     the response register loads, so the next request sees the new recency
//   stall: when rsp_stall holds a waiting response, the request register
//     keeps its word and req_stall rises until the response is taken
//   reset: rst clears the valid marks, ranks, fill count and both pipeline
//     registers' valid bits; the store is empty and usable right after
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire lkvc_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output lkvc_pkg::rsp_t     rsp
);

  // request register
  logic           req_q_valid;
  lkvc_pkg::req_t req_q;

  // response computed from the request register
  lkvc_pkg::rsp_t rsp_next;

  // the held request moves on when the response register is free or draining
  logic adv;

  assign adv       = req_q_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = req_q_valid && !adv;

  lkvc_store u_store (
    .clk (clk),
    .rst (rst),
    .adv (adv),
    .req (req_q),
    .rsp (rsp_next)
  );

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (!req_stall) begin
        req_q_valid <= req_valid;
      end
      if (adv) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      req_q <= req;
    end
    if (adv) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire
